FILE: rtl/bic_pkg.sv
`timescale 1ns / 1ps
// package for the banked interrupt controller
// transaction structs, register word codes and the lowest-set-bit encoders; no dependencies

package bic_pkg;

  localparam int unsigned BankWidth  = 32;
  localparam int unsigned BasicWidth = 8;
  localparam int unsigned NumSources = 2 * BankWidth + BasicWidth;

  localparam logic [6:0] HighOffset  = 7'd32;
  localparam logic [6:0] BasicOffset = 7'd64;

  localparam logic [1:0] ReqRead   = 2'd0;
  localparam logic [1:0] ReqWrite  = 2'd1;
  localparam logic [1:0] ReqSample = 2'd2;

  localparam logic [3:0] WordPendBasic = 4'd0;
  localparam logic [3:0] WordPendLow   = 4'd1;
  localparam logic [3:0] WordPendHigh  = 4'd2;
  localparam logic [3:0] WordEnLow     = 4'd4;
  localparam logic [3:0] WordEnHigh    = 4'd5;
  localparam logic [3:0] WordEnBasic   = 4'd6;
  localparam logic [3:0] WordDisLow    = 4'd7;
  localparam logic [3:0] WordDisHigh   = 4'd8;
  localparam logic [3:0] WordDisBasic  = 4'd9;

  localparam int unsigned LowAnyBit  = 8;
  localparam int unsigned HighAnyBit = 9;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  reg_word;
    logic [31:0] write_data;
    logic [31:0] src_low_bank;
    logic [31:0] src_high_bank;
    logic [7:0]  src_basic_bank;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
    logic [6:0]  next_source;
    logic        next_valid;
  } rsp_t;

  typedef struct packed {
    logic [31:0] enable_low;
    logic [31:0] enable_high;
    logic [7:0]  enable_basic;
    logic [31:0] level_low;
    logic [31:0] level_high;
    logic [7:0]  level_basic;
  } state_t;

  function automatic logic [4:0] lowest_set32(input logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  function automatic logic [2:0] lowest_set8(input logic [7:0] v);
    logic [2:0] idx;
    idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) idx = 3'(i);
    end
    return idx;
  endfunction

endpackage

FILE: rtl/bic_state.sv
`timescale 1ns / 1ps
// enable and source level registers of the banked interrupt controller
// applies one transaction to the state; depends on bic_pkg

module bic_state (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            commit_i,
  input  bic_pkg::req_t   req_i,
  output bic_pkg::state_t state_o
);
  import bic_pkg::*;

  state_t state_q, state_d;

  always_comb begin
    state_d = state_q;
    if (req_i.req_type == ReqWrite) begin
      case (req_i.reg_word)
        WordEnLow:    state_d.enable_low   = state_q.enable_low | req_i.write_data;
        WordEnHigh:   state_d.enable_high  = state_q.enable_high | req_i.write_data;
        WordEnBasic:  state_d.enable_basic = state_q.enable_basic | req_i.write_data[7:0];
        WordDisLow:   state_d.enable_low   = state_q.enable_low & ~req_i.write_data;
        WordDisHigh:  state_d.enable_high  = state_q.enable_high & ~req_i.write_data;
        WordDisBasic: state_d.enable_basic = state_q.enable_basic & ~req_i.write_data[7:0];
        default: ;
      endcase
    end else if (req_i.req_type == ReqSample) begin
      state_d.level_low   = req_i.src_low_bank;
      state_d.level_high  = req_i.src_high_bank;
      state_d.level_basic = req_i.src_basic_bank;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (commit_i) begin
      state_q <= state_d;
    end
  end

  // state as seen after the transaction has taken effect
  assign state_o = state_d;

endmodule

FILE: rtl/bic_resolve.sv
`timescale 1ns / 1ps
// pending masks, register read mux and next-source priority select
// purely combinational; depends on bic_pkg

module bic_resolve (
  input  bic_pkg::req_t   req_i,
  input  bic_pkg::state_t state_i,
  output bic_pkg::rsp_t   rsp_o
);
  import bic_pkg::*;

  logic [31:0] pend_low, pend_high, basic_word;
  logic [7:0]  pend_basic;
  logic [31:0] rdata;

  assign pend_low   = state_i.level_low & state_i.enable_low;
  assign pend_high  = state_i.level_high & state_i.enable_high;
  assign pend_basic = state_i.level_basic & state_i.enable_basic;

  always_comb begin
    basic_word             = {24'd0, pend_basic};
    basic_word[LowAnyBit]  = |pend_low;
    basic_word[HighAnyBit] = |pend_high;
  end

  always_comb begin
    rdata = '0;
    if (req_i.req_type == ReqRead) begin
      case (req_i.reg_word)
        WordPendBasic:            rdata = basic_word;
        WordPendLow:              rdata = pend_low;
        WordPendHigh:             rdata = pend_high;
        WordEnLow, WordDisLow:     rdata = state_i.enable_low;
        WordEnHigh, WordDisHigh:   rdata = state_i.enable_high;
        WordEnBasic, WordDisBasic: rdata = {24'd0, state_i.enable_basic};
        default:                  rdata = '0;
      endcase
    end
  end

  always_comb begin
    rsp_o.read_data   = rdata;
    rsp_o.next_source = '0;
    rsp_o.next_valid  = 1'b0;
    // basic lines first, then low bank, then high bank
    if (|pend_basic) begin
      rsp_o.next_source = BasicOffset + {4'd0, lowest_set8(pend_basic)};
      rsp_o.next_valid  = 1'b1;
    end else if (|pend_low) begin
      rsp_o.next_source = {2'd0, lowest_set32(pend_low)};
      rsp_o.next_valid  = 1'b1;
    end else if (|pend_high) begin
      rsp_o.next_source = HighOffset + {2'd0, lowest_set32(pend_high)};
      rsp_o.next_valid  = 1'b1;
    end
    rsp_o.irq_line = rsp_o.next_valid;
  end

endmodule

FILE: rtl/banked_interrupt_controller.sv
`timescale 1ns / 1ps
// Banked level-sensitive interrupt controller for 72 sources (32 low, 32 high, 8 basic lines).
// Every transaction is a bus read, a bus write or a source level sample and yields one
// response carrying the read word, the interrupt line and the next source to serve. The block
// takes one transaction per cycle while in_stall_o is low. A transaction is first held in the
// input register; then the enable/level update, pending masks and priority encoders settle in
// a single pass into the result register, which drives the outputs. The result register is a
// pipeline stage, so a new transaction is accepted while a response waits to be taken;
// in_stall_o rises only when both stages are full and the output is stalled.

module banked_interrupt_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bic_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bic_pkg::rsp_t out_data_o
);
  import bic_pkg::*;

  req_t   in_q;
  logic   in_valid_q;
  rsp_t   out_q, rsp;
  logic   out_valid_q;
  state_t state_nxt;
  logic   advance, in_load, commit;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_load    = !in_valid_q || advance;
  assign commit     = in_valid_q && advance;
  assign in_stall_o = !in_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) in_q <= in_data_i;
    if (commit) out_q <= rsp;
  end

  bic_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .req_i    (in_q),
    .state_o  (state_nxt)
  );

  bic_resolve u_resolve (
    .req_i   (in_q),
    .state_i (state_nxt),
    .rsp_o   (rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // input stalls only when both stages hold a transaction and the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a full pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.next_valid) |-> (out_data_o.next_source == 7'd0))
    else $error("next source set with nothing pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.next_source < 7'(NumSources)))
    else $error("next source out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && advance) |=> out_valid_o)
    else $error("transaction lost between stages");

endmodule
